/* design/nmvs_pkg.sv */
`default_nettype none

package nmvs_pkg;

	localparam int MAX_NTH    = 64;
	localparam int VALUE_BITS = 64;
	localparam int IDX_W      = 8;
	localparam int CNT_W      = $clog2(MAX_NTH + 1);
	localparam int POS_W      = (MAX_NTH > 1) ? $clog2(MAX_NTH) : 1;
	localparam int CMP_W      = ((CNT_W > IDX_W) ? CNT_W : IDX_W) + 1;

	typedef logic signed [IDX_W-1:0] nth_t;
	typedef logic [CNT_W-1:0]        count_t;
	typedef logic [POS_W-1:0]        pos_t;

	typedef struct packed {
		logic [VALUE_BITS-1:0] value;
		logic                  is_null;
	} entry_t;

	typedef struct packed {
		logic shift;
		logic clear;
		logic sel_valid;
		pos_t sel_pos;
	} chain_ctrl_t;

endpackage

`default_nettype wire

/* design/nmvs_cell.sv */
`default_nettype none

module nmvs_cell (
	input  wire                  clk,
	input  wire                  arst_n,
	input  nmvs_pkg::pos_t       pos,
	input  nmvs_pkg::chain_ctrl_t ctl,
	input  nmvs_pkg::entry_t     prev_entry,
	output nmvs_pkg::entry_t     entry,
	output nmvs_pkg::entry_t     pick
);
	import nmvs_pkg::*;

	entry_t entry_q;
	entry_t entry_nx;

	always_comb begin
		entry_nx = ctl.shift ? prev_entry : entry_q;
		pick     = (ctl.sel_valid && (pos == ctl.sel_pos)) ? entry_nx : '0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= '0;
		end else if (ctl.clear) begin
			entry_q <= '0;
		end else begin
			entry_q <= entry_nx;
		end
	end

	assign entry = entry_q;

endmodule

`default_nettype wire

/* design/nmvs_tally.sv */
`default_nettype none

module nmvs_tally (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   accept,
	input  wire                   match,
	input  wire                   window_end,
	input  nmvs_pkg::entry_t      row,
	input  nmvs_pkg::nth_t        nth,
	output nmvs_pkg::chain_ctrl_t ctl,
	output nmvs_pkg::entry_t      cap_pick,
	output logic                  cap_ok
);
	import nmvs_pkg::*;

	count_t             match_count_q;
	count_t             count_nx;
	entry_t             captured_q;
	logic               captured_valid_q;
	logic               counted;
	logic               n_neg;
	logic               n_pos;
	logic [IDX_W-1:0]   mag;
	logic [CMP_W-1:0]   mag_x;
	logic               cap_hit;
	logic               capv_nx;

	always_comb begin
		n_neg    = nth[IDX_W-1];
		n_pos    = !n_neg && (nth != '0);
		mag      = n_neg ? IDX_W'(-nth) : IDX_W'(nth);
		mag_x    = CMP_W'(mag);
		counted  = match && (match_count_q < CNT_W'(MAX_NTH));
		count_nx = counted ? CNT_W'(match_count_q + 1'b1) : match_count_q;
		cap_hit  = n_neg && counted && !captured_valid_q && (CMP_W'(count_nx) == mag_x);
		capv_nx  = captured_valid_q || cap_hit;
		cap_pick = cap_hit ? row : captured_q;
		cap_ok   = n_neg && capv_nx;

		ctl.shift     = accept && match && n_pos;
		ctl.clear     = accept && window_end;
		ctl.sel_valid = n_pos && (mag_x <= CMP_W'(count_nx))
			&& (mag_x <= CMP_W'(MAX_NTH));
		ctl.sel_pos   = POS_W'(mag - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_count_q    <= '0;
			captured_q       <= '0;
			captured_valid_q <= 1'b0;
		end else if (accept) begin
			if (window_end) begin
				match_count_q    <= '0;
				captured_q       <= '0;
				captured_valid_q <= 1'b0;
			end else begin
				match_count_q    <= count_nx;
				captured_q       <= cap_pick;
				captured_valid_q <= capv_nx;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		match_count_q <= CNT_W'(MAX_NTH))
		else $error("match count above limit");

	a_clear_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		accept && window_end |=> (match_count_q == '0) && !captured_valid_q)
		else $error("window state not cleared");

	a_capture_once: assert property (@(posedge clk) disable iff (!arst_n)
		captured_valid_q && $past(captured_valid_q) |-> $stable(captured_q))
		else $error("captured word overwritten");

endmodule

`default_nettype wire

/* design/nth_matching_value_select_core.sv */
// Picks the nth matching value of a window of rows.
// Input channel: one word per row (row_value, null flags, match condition,
// row_present, window_end), accepted when in_valid is high and in_stall low.
// Rows arrive from window end towards window start. A word with window_end
// closes the window and yields exactly one result word.
// Output channel: result_value and result_null, taken when out_valid is high
// and out_stall low. result_value is zero whenever result_null is set.
// Config: cfg_wr_en writes cfg_wr_data into the signed nth index. Positive
// picks from window start, negative from window end, zero gives null.
// One word per cycle while in_stall is low; a matching row shifts the
// 64-cell match chain once if nth is positive. The result is registered.
// in_stall rises only while a result sits in the output register and
// out_stall is high; a word is taken in the same cycle the result leaves.
// Reset clears the chain, the match count, the capture and the index.
`default_nettype none

module nth_matching_value_select_core (
	input  wire                 clk,
	input  wire                 arst_n,
	input  wire                 cfg_wr_en,
	input  nmvs_pkg::nth_t      cfg_wr_data,
	input  wire                 in_valid,
	output logic                in_stall,
	input  wire  [63:0]         row_value,
	input  wire                 row_value_null,
	input  wire                 match_cond,
	input  wire                 match_cond_null,
	input  wire                 row_present,
	input  wire                 window_end,
	output logic                out_valid,
	input  wire                 out_stall,
	output logic [63:0]         result_value,
	output logic                result_null
);
	import nmvs_pkg::*;

	nth_t        nth_q;
	logic        accept;
	logic        match;
	entry_t      row;
	chain_ctrl_t ctl;
	entry_t      cap_pick;
	logic        cap_ok;
	entry_t      chain [MAX_NTH];
	entry_t      picks [MAX_NTH];
	entry_t      chain_pick;
	entry_t      res;
	logic        res_null;
	logic [63:0] res_value;
	logic        out_valid_q;
	logic [63:0] result_value_q;
	logic        result_null_q;

	assign in_stall = out_valid_q && out_stall;
	assign accept   = in_valid && !in_stall;
	assign match    = row_present && match_cond && !match_cond_null;

	always_comb begin
		row.value   = row_value[VALUE_BITS-1:0];
		row.is_null = row_value_null;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nth_q <= '0;
		end else if (cfg_wr_en) begin
			nth_q <= cfg_wr_data;
		end
	end

	nmvs_tally u_tally (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.match      (match),
		.window_end (window_end),
		.row        (row),
		.nth        (nth_q),
		.ctl        (ctl),
		.cap_pick   (cap_pick),
		.cap_ok     (cap_ok)
	);

	for (genvar k = 0; k < MAX_NTH; k++) begin : g_cell
		nmvs_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.pos        (POS_W'(k)),
			.ctl        (ctl),
			.prev_entry ((k == 0) ? row : chain[(k == 0) ? 0 : k - 1]),
			.entry      (chain[k]),
			.pick       (picks[k])
		);
	end

	always_comb begin
		chain_pick = '0;
		for (int i = 0; i < MAX_NTH; i++) begin
			chain_pick = chain_pick | picks[i];
		end
		priority if (ctl.sel_valid) begin
			res      = chain_pick;
			res_null = chain_pick.is_null;
		end else if (cap_ok) begin
			res      = cap_pick;
			res_null = cap_pick.is_null;
		end else begin
			res      = '0;
			res_null = 1'b1;
		end
		res_value = res_null ? 64'd0 : 64'(res.value);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && window_end) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && window_end) begin
			result_value_q <= res_value;
			result_null_q  <= res_null;
		end
	end

	assign out_valid    = out_valid_q;
	assign result_value = result_value_q;
	assign result_null  = result_null_q;

	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && result_null |-> result_value == 64'd0)
		else $error("null result with nonzero value");

	a_end_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		accept && window_end |=> out_valid)
		else $error("closing word gave no result");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled with free output register");

endmodule

`default_nettype wire
